// ===== design/ctt_pkg.sv =====
// shared types, codes and constants of the commutation timing tracker
package ctt_pkg;

    localparam int AVG_COUNT     = 4;
    localparam int DELAY_DIVIDER = 2;

    localparam int STAMP_W = 16;
    localparam int SUM_W   = 18;

    localparam logic [SUM_W-1:0] AVG_DIV  = SUM_W'(AVG_COUNT);
    localparam logic [SUM_W-1:0] SCAN_DIV = SUM_W'(AVG_COUNT * DELAY_DIVIDER);

    localparam logic [1:0] OP_UPDATE   = 2'd0;
    localparam logic [1:0] OP_ARM_SCAN = 2'd1;
    localparam logic [1:0] OP_ARM_ZERO = 2'd2;
    localparam logic [1:0] OP_RESTORE  = 2'd3;

    localparam logic [SUM_W-1:0]   SUM_MAX       = 18'h3FFFF;
    localparam logic [STAMP_W-1:0] W16_MAX       = 16'hFFFF;
    localparam logic [STAMP_W-1:0] START_SCAN    = 16'h1FFF;
    localparam logic [STAMP_W-1:0] START_TIMEOUT = 16'hFFFF;

    typedef struct packed {
        logic [1:0]         operation;
        logic [STAMP_W-1:0] timer_now;
        logic [STAMP_W-1:0] delay_ticks;
    } t_in_item;

    typedef struct packed {
        logic [STAMP_W-1:0] compare_value;
        logic [STAMP_W-1:0] previous_stamp;
        logic [STAMP_W-1:0] zero_wait;
        logic [STAMP_W-1:0] scan_wait;
        logic [SUM_W-1:0]   average_period;
    } t_out_item;

    typedef struct packed {
        logic [STAMP_W-1:0] last_stamp;
        logic [SUM_W-1:0]   period_sum;
        logic [STAMP_W-1:0] timeout_wait;
        logic [STAMP_W-1:0] commutation_wait;
    } t_state;

endpackage

// ===== design/commutation_timing_tracker.sv =====
// top level: input stage, timing state, result register and advance register
//
//  channel   direction  handshake               payload
//  in        input      i_in_valid / o_in_ready   i_in_item  (t_in_item)
//  out       output     o_out_valid / i_out_ready o_out_item (t_out_item)
//  cfg       input      i_cfg_valid / o_cfg_ready i_cfg_data (advance ticks)
//
// one item per cycle unless the result stalls; an item is held in the input
// stage, and its update runs between the input stage and the result register
// synchronous active-low reset restores the start-up timing values
// a stalled result holds while the input stage still takes one more item
module commutation_timing_tracker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  ctt_pkg::t_in_item            i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output ctt_pkg::t_out_item           o_out_item,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ctt_pkg::STAMP_W-1:0]  i_cfg_data
);

    logic                        r_in_valid;
    ctt_pkg::t_in_item           r_in_item;
    logic                        r_out_valid;
    ctt_pkg::t_out_item          r_out_item;
    ctt_pkg::t_state             r_state;
    logic [ctt_pkg::STAMP_W-1:0] r_advance;

    ctt_pkg::t_state             n_state;
    ctt_pkg::t_out_item          n_out_item;
    logic                        advance;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    ctt_update u_update (
        .i_item    (r_in_item),
        .i_state   (r_state),
        .i_advance (r_advance),
        .o_state   (n_state),
        .o_result  (n_out_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid               <= 1'b0;
            r_out_valid              <= 1'b0;
            r_advance                <= '0;
            r_state.last_stamp       <= '0;
            r_state.period_sum       <= ctt_pkg::SUM_MAX;
            r_state.timeout_wait     <= ctt_pkg::START_TIMEOUT;
            r_state.commutation_wait <= ctt_pkg::START_SCAN;
        end else begin
            if (i_cfg_valid) begin
                r_advance <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed item produced no result");

    a_result_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (o_out_item.average_period == r_state.period_sum)
                 && (o_out_item.scan_wait == r_state.commutation_wait)
                 && (o_out_item.zero_wait == r_state.timeout_wait))
        else $error("result disagrees with timing state");

    a_arm_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_in_item.operation == ctt_pkg::OP_ARM_SCAN
                  || r_in_item.operation == ctt_pkg::OP_ARM_ZERO))
        |=> $stable(r_state))
        else $error("arm item changed timing state");

    a_restore_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_item.operation == ctt_pkg::OP_RESTORE)
        |=> (r_state.period_sum == ctt_pkg::SUM_MAX)
         && (o_out_item.compare_value == '0))
        else $error("restore item left wrong values");

endmodule

// ===== design/ctt_update.sv =====
// combinational timing update for one item: next state and result
module ctt_update (
    input  ctt_pkg::t_in_item                i_item,
    input  ctt_pkg::t_state                  i_state,
    input  logic [ctt_pkg::STAMP_W-1:0]      i_advance,
    output ctt_pkg::t_state                  o_state,
    output ctt_pkg::t_out_item               o_result
);

    logic [ctt_pkg::STAMP_W-1:0] period;
    logic [ctt_pkg::SUM_W:0]     sum_raw;
    logic [ctt_pkg::SUM_W-1:0]   sum_sat;
    logic [ctt_pkg::SUM_W-1:0]   scan_raw;
    logic [ctt_pkg::SUM_W-1:0]   scan_sub;
    logic [ctt_pkg::STAMP_W-1:0] scan_sat;
    logic [ctt_pkg::STAMP_W-1:0] zero_sat;
    logic [ctt_pkg::STAMP_W-1:0] compare;
    ctt_pkg::t_state             nxt;

    always_comb begin
        period  = i_item.timer_now - i_state.last_stamp;
        sum_raw = {1'b0, i_state.period_sum}
                - {1'b0, i_state.period_sum / ctt_pkg::AVG_DIV}
                + {{(ctt_pkg::SUM_W + 1 - ctt_pkg::STAMP_W){1'b0}}, period};
        sum_sat = (sum_raw > {1'b0, ctt_pkg::SUM_MAX}) ? ctt_pkg::SUM_MAX
                                                       : sum_raw[ctt_pkg::SUM_W-1:0];
        scan_raw = sum_sat / ctt_pkg::SCAN_DIV;
        scan_sub = (scan_raw > {{(ctt_pkg::SUM_W - ctt_pkg::STAMP_W){1'b0}}, i_advance})
                 ? scan_raw - {{(ctt_pkg::SUM_W - ctt_pkg::STAMP_W){1'b0}}, i_advance}
                 : '0;
        scan_sat = (scan_sub > {{(ctt_pkg::SUM_W - ctt_pkg::STAMP_W){1'b0}},
                                ctt_pkg::W16_MAX})
                 ? ctt_pkg::W16_MAX : scan_sub[ctt_pkg::STAMP_W-1:0];
        zero_sat = (i_state.period_sum > {{(ctt_pkg::SUM_W - ctt_pkg::STAMP_W){1'b0}},
                                          ctt_pkg::W16_MAX})
                 ? ctt_pkg::W16_MAX : i_state.period_sum[ctt_pkg::STAMP_W-1:0];

        nxt     = i_state;
        compare = '0;
        unique case (i_item.operation)
            ctt_pkg::OP_UPDATE: begin
                nxt.timeout_wait     = zero_sat;
                nxt.last_stamp       = i_item.timer_now;
                nxt.period_sum       = sum_sat;
                nxt.commutation_wait = scan_sat;
                compare              = i_item.timer_now + i_item.delay_ticks;
            end
            ctt_pkg::OP_ARM_SCAN: begin
                compare = i_item.timer_now + i_state.commutation_wait;
            end
            ctt_pkg::OP_ARM_ZERO: begin
                compare = i_item.timer_now + i_state.timeout_wait;
            end
            ctt_pkg::OP_RESTORE: begin
                nxt.period_sum       = ctt_pkg::SUM_MAX;
                nxt.commutation_wait = ctt_pkg::START_SCAN;
                nxt.timeout_wait     = ctt_pkg::START_TIMEOUT;
            end
            default: begin
                nxt = i_state;
            end
        endcase

        o_state                 = nxt;
        o_result.compare_value  = compare;
        o_result.previous_stamp = i_state.last_stamp;
        o_result.zero_wait      = nxt.timeout_wait;
        o_result.scan_wait      = nxt.commutation_wait;
        o_result.average_period = nxt.period_sum;
    end

endmodule

// ===== tb/tb_top.sv =====
// testbench for the commutation timing tracker: random and directed items, scoreboard check
`timescale 1ns / 1ps

module tb_top;
    import ctt_pkg::*;

    class timing_scoreboard;
        t_out_item          expected_q[$];
        logic [STAMP_W-1:0] last_stamp;
        logic [SUM_W-1:0]   period_sum;
        logic [STAMP_W-1:0] timeout_wait;
        logic [STAMP_W-1:0] commutation_wait;
        logic [STAMP_W-1:0] advance;
        int                 errors;
        int                 n_checked;
        int                 n_cfg;
        int                 n_ops[4];

        function new();
            errors = 0;
            n_checked = 0;
            n_cfg = 0;
            foreach (n_ops[k]) n_ops[k] = 0;
            last_stamp = '0;
            advance = '0;
            restore_startup();
        endfunction

        function void restore_startup();
            period_sum = SUM_MAX;
            commutation_wait = START_SCAN;
            timeout_wait = START_TIMEOUT;
        endfunction

        function void set_advance(logic [STAMP_W-1:0] value);
            advance = value;
            n_cfg++;
        endfunction

        function void note_input(t_in_item it);
            t_out_item   exp;
            int unsigned ps;
            int unsigned per;
            int unsigned sum;
            int unsigned scan;
            exp.previous_stamp = last_stamp;
            n_ops[it.operation]++;
            case (it.operation)
                OP_UPDATE: begin
                    timeout_wait = (period_sum > SUM_W'(W16_MAX)) ? W16_MAX
                                                                   : period_sum[STAMP_W-1:0];
                    per = 32'(STAMP_W'(it.timer_now - last_stamp));
                    last_stamp = it.timer_now;
                    ps = 32'(period_sum);
                    sum = ps - ps / AVG_COUNT + per;
                    if (sum > 32'(SUM_MAX)) sum = 32'(SUM_MAX);
                    period_sum = SUM_W'(sum);
                    scan = sum / AVG_COUNT / DELAY_DIVIDER;
                    scan = (scan > 32'(advance)) ? scan - 32'(advance) : 0;
                    if (scan > 32'(W16_MAX)) scan = 32'(W16_MAX);
                    commutation_wait = STAMP_W'(scan);
                    exp.compare_value = STAMP_W'(it.timer_now + it.delay_ticks);
                end
                OP_ARM_SCAN: exp.compare_value = STAMP_W'(it.timer_now + commutation_wait);
                OP_ARM_ZERO: exp.compare_value = STAMP_W'(it.timer_now + timeout_wait);
                default: begin
                    restore_startup();
                    exp.compare_value = '0;
                end
            endcase
            exp.zero_wait = timeout_wait;
            exp.scan_wait = commutation_wait;
            exp.average_period = period_sum;
            expected_q.push_back(exp);
        endfunction

        function void check_field(string name, logic [SUM_W-1:0] exp, logic [SUM_W-1:0] act);
            if (act !== exp) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            exp = expected_q.pop_front();
            n_checked++;
            check_field("compare_value", SUM_W'(exp.compare_value), SUM_W'(got.compare_value));
            check_field("previous_stamp", SUM_W'(exp.previous_stamp),
                        SUM_W'(got.previous_stamp));
            check_field("zero_wait", SUM_W'(exp.zero_wait), SUM_W'(got.zero_wait));
            check_field("scan_wait", SUM_W'(exp.scan_wait), SUM_W'(got.scan_wait));
            check_field("average_period", exp.average_period, got.average_period);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void finish_check();
            if (expected_q.size() != 0) begin
                errors += expected_q.size();
                $display("%0t: %0d results missing, expected %h first, actual none",
                         $time, expected_q.size(), expected_q[0]);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    t_in_item           i_in_item = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_out_item          o_out_item;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [STAMP_W-1:0] i_cfg_data = '0;

    timing_scoreboard   sb;
    int                 idle_pct = 0;
    int                 stall_pct = 0;
    logic               hold_active = 1'b0;
    logic [STAMP_W-1:0] tmr = '0;

    commutation_timing_tracker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (hold_active) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) sb.check_result(o_out_item);
            if (i_in_valid && o_in_ready) sb.note_input(i_in_item);
            if (i_cfg_valid && o_cfg_ready) sb.set_advance(i_cfg_data);
        end
    end

    function automatic t_in_item mk(logic [1:0] op, logic [STAMP_W-1:0] t,
                                    logic [STAMP_W-1:0] d);
        t_in_item it;
        it.operation = op;
        it.timer_now = t;
        it.delay_ticks = d;
        return it;
    endfunction

    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_results_done(int limit);
        int n;
        n = 0;
        i_in_valid <= 1'b0;
        while (sb.pending() != 0 && n < limit) begin
            @(posedge i_clk);
            n++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_advance(logic [STAMP_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic hold_receiver(int cycles);
        hold_active <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_active <= 1'b0;
    endtask

    task automatic run_phase(int n, int idle, int stall);
        t_in_item    it;
        int unsigned kind;
        int unsigned step;
        idle_pct = idle;
        stall_pct = stall;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(99);
            it.delay_ticks = ($urandom_range(1) != 0) ? 16'($urandom_range(65535))
                                                      : 16'($urandom_range(2000));
            if (kind < 55) begin
                case ($urandom_range(3))
                    0: step = $urandom_range(65535);
                    1: step = $urandom_range(20000, 60000);
                    default: step = $urandom_range(50, 4000);
                endcase
                tmr = tmr + 16'(step);
                it.operation = OP_UPDATE;
                it.timer_now = tmr;
            end else if (kind < 72) begin
                it.operation = OP_ARM_SCAN;
                it.timer_now = tmr + 16'($urandom_range(100));
            end else if (kind < 85) begin
                it.operation = OP_ARM_ZERO;
                it.timer_now = tmr + 16'($urandom_range(100));
            end else if (kind < 88) begin
                it.operation = OP_RESTORE;
                it.timer_now = 16'($urandom_range(65535));
            end else begin
                it.operation = 2'($urandom_range(3));
                it.timer_now = 16'($urandom_range(65535));
                it.delay_ticks = 16'($urandom_range(65535));
            end
            send_item(it);
        end
        wait_results_done(20000);
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(mk(OP_ARM_SCAN, 16'h1234, 16'h0000));
        send_item(mk(OP_ARM_ZERO, 16'hFFFF, 16'hFFFF));
        send_item(mk(OP_UPDATE,   16'h0000, 16'h0000));
        send_item(mk(OP_UPDATE,   16'hFFFF, 16'hFFFF));
        send_item(mk(OP_UPDATE,   16'h0000, 16'h0001));
        send_item(mk(OP_ARM_SCAN, 16'hFFFF, 16'h0000));
        send_item(mk(OP_ARM_ZERO, 16'h8000, 16'h0000));
        send_item(mk(OP_RESTORE,  16'hAAAA, 16'h5555));
        send_item(mk(OP_ARM_SCAN, 16'h0001, 16'h0000));
        send_item(mk(OP_ARM_ZERO, 16'h0001, 16'h0000));
        for (int i = 1; i <= 4; i++) begin
            send_item(mk(OP_UPDATE, 16'(i * 16'h0100), 16'h0040));
        end
        send_item(mk(OP_UPDATE,   16'h5555, 16'hAAAA));
        wait_results_done(20000);

        // advance above every possible scan wait, so scan wait floors at zero
        write_advance(16'hFFFF);
        send_item(mk(OP_UPDATE,   16'h5755, 16'h0010));
        send_item(mk(OP_ARM_SCAN, 16'h5800, 16'h0000));
        send_item(mk(OP_ARM_ZERO, 16'h5900, 16'h0000));
        send_item(mk(OP_RESTORE,  16'h0000, 16'h0000));
        send_item(mk(OP_UPDATE,   16'h6000, 16'h7FFF));
        wait_results_done(20000);
        tmr = 16'h6000;

        write_advance(16'h0001);
        run_phase(360, 0, 0);
        write_advance(16'($urandom_range(65535)));
        run_phase(360, 69, 0);
        write_advance(16'h0000);
        run_phase(360, 0, 69);
        write_advance(16'h0400);
        run_phase(360, 20, 20);

        fork
            hold_receiver(300);
        join_none
        run_phase(40, 0, 0);

        write_advance(16'($urandom_range(16'h2000)));
        run_phase(360, 0, 0);

        sb.finish_check();
        $display("ran %0d updates, %0d scan arms, %0d timeout arms, %0d restores",
                 sb.n_ops[OP_UPDATE], sb.n_ops[OP_ARM_SCAN], sb.n_ops[OP_ARM_ZERO],
                 sb.n_ops[OP_RESTORE]);
        $display("%0d advance writes, %0d results checked, %0d mismatches",
                 sb.n_cfg, sb.n_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
